// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

// ===== src/lbi_pkg.sv =====
// ----------------------------------------------------------------------------
// lbi_pkg
// Shared types and constants of the laser blank inserter.
// ----------------------------------------------------------------------------
package lbi_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_PRE_BLANKS  = 2'd0;
    localparam logic [1:0] CFG_POST_BLANKS = 2'd1;
    localparam logic [1:0] CFG_MIN_DIST    = 2'd2;

    // register reset values and limits
    localparam logic [3:0]  PRE_RESET  = 4'd3;
    localparam logic [4:0]  POST_RESET = 5'd16;
    localparam logic [15:0] DIST_RESET = 16'd50;
    localparam logic [3:0]  PRE_MAX    = 4'd8;
    localparam logic [4:0]  POST_MAX   = 5'd24;

    // mirror travel covered by one slew copy (full scale / 20)
    localparam logic [15:0] SLEW_STEP = 16'd3276;

    // item command codes
    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_EOF   = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic emit_lit;
        logic start_run;
        logic emit_pre;
        logic emit_slew;
        logic emit_post;
        logic last;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_lit;
        logic run_req;
        logic pre_zero;
        logic post_zero;
        logic cnt_last;
        logic slew_last;
        logic slot_free;
    } t_dp_status;

endpackage

// ===== src/lbi_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbi_ctrl
// Sequencer: accepts words and steps through the pre, slew and post phases
// of a blanking run.
// ----------------------------------------------------------------------------
module lbi_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  lbi_pkg::t_dp_status i_status,
    output logic               o_in_ready,
    output lbi_pkg::t_dp_cmd   o_cmd
);
    import lbi_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PRE  = 4'b0010,
        ST_SLEW = 4'b0100,
        ST_POST = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = i_status.slot_free;
                if (i_in_valid && i_status.slot_free) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.in_lit) begin
                        o_cmd.emit_lit = 1'b1;
                        o_cmd.last     = 1'b1;
                    end else if (i_status.run_req) begin
                        o_cmd.start_run = 1'b1;
                        n_state = i_status.pre_zero ? ST_SLEW : ST_PRE;
                    end
                end
            end
            ST_PRE: begin
                if (i_status.slot_free) begin
                    o_cmd.emit_pre = 1'b1;
                    if (i_status.cnt_last) begin
                        n_state = ST_SLEW;
                    end
                end
            end
            ST_SLEW: begin
                if (i_status.slot_free) begin
                    o_cmd.emit_slew = 1'b1;
                    if (i_status.slew_last) begin
                        o_cmd.last = i_status.post_zero;
                        n_state    = i_status.post_zero ? ST_IDLE : ST_POST;
                    end
                end
            end
            ST_POST: begin
                if (i_status.slot_free) begin
                    o_cmd.emit_post = 1'b1;
                    if (i_status.cnt_last) begin
                        o_cmd.last = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/lbi_datapath.sv =====
// ----------------------------------------------------------------------------
// lbi_datapath
// Position state, configuration registers, run counters and output register.
// ----------------------------------------------------------------------------
module lbi_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration writes
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    // input word fields
    input  logic                i_command,
    input  logic signed [15:0]  i_pos_x,
    input  logic signed [15:0]  i_pos_y,
    input  logic [15:0]         i_red,
    input  logic [15:0]         i_green,
    input  logic [15:0]         i_blue,
    // output side
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic signed [15:0]  o_out_x,
    output logic signed [15:0]  o_out_y,
    output logic [15:0]         o_out_red,
    output logic [15:0]         o_out_green,
    output logic [15:0]         o_out_blue,
    output logic                o_last_of_run,
    // controller link
    input  lbi_pkg::t_dp_cmd    i_cmd,
    output lbi_pkg::t_dp_status o_status
);
    import lbi_pkg::*;

    // configuration
    logic [3:0]  r_pre_blanks;
    logic [4:0]  r_post_blanks;
    logic [15:0] r_min_dist;

    // frame state
    logic signed [15:0] r_prev_x;
    logic signed [15:0] r_prev_y;
    logic               r_prev_unlit;
    logic               r_frame_has_output;

    // run state
    logic signed [15:0] r_dep_x;
    logic signed [15:0] r_dep_y;
    logic signed [15:0] r_tgt_x;
    logic signed [15:0] r_tgt_y;
    logic [15:0]        r_rem;
    logic [4:0]         r_cnt;

    // output register
    logic               r_out_valid;
    logic signed [15:0] r_out_x;
    logic signed [15:0] r_out_y;
    logic [15:0]        r_out_red;
    logic [15:0]        r_out_green;
    logic [15:0]        r_out_blue;
    logic               r_out_last;

    logic               w_eof;
    logic               w_lit;
    logic signed [15:0] w_tgt_x;
    logic signed [15:0] w_tgt_y;
    logic signed [16:0] w_dx;
    logic signed [16:0] w_dy;
    logic [15:0]        w_adx;
    logic [15:0]        w_ady;
    logic [15:0]        w_dist;
    logic               w_need_run;
    logic [3:0]         w_pre;
    logic [4:0]         w_post;
    logic               w_emit;

    // decode the input word
    assign w_eof   = (i_command == CMD_EOF);
    assign w_lit   = !w_eof && ((i_red | i_green | i_blue) != 16'd0);
    assign w_tgt_x = w_eof ? 16'sd0 : i_pos_x;
    assign w_tgt_y = w_eof ? 16'sd0 : i_pos_y;

    // Chebyshev distance from the last position
    assign w_dx  = {r_prev_x[15], r_prev_x} - {w_tgt_x[15], w_tgt_x};
    assign w_dy  = {r_prev_y[15], r_prev_y} - {w_tgt_y[15], w_tgt_y};
    assign w_adx = w_dx[16] ? 16'(-w_dx) : w_dx[15:0];
    assign w_ady = w_dy[16] ? 16'(-w_dy) : w_dy[15:0];
    assign w_dist     = (w_adx > w_ady) ? w_adx : w_ady;
    assign w_need_run = (w_dist > r_min_dist);

    // saturate the copy counts
    assign w_pre  = (r_pre_blanks > PRE_MAX) ? PRE_MAX : r_pre_blanks;
    assign w_post = (r_post_blanks > POST_MAX) ? POST_MAX : r_post_blanks;

    assign w_emit = i_cmd.emit_lit | i_cmd.emit_pre | i_cmd.emit_slew | i_cmd.emit_post;

    // status to the controller
    always_comb begin
        o_status.in_lit    = w_lit;
        o_status.run_req   = w_eof ? (r_frame_has_output && w_need_run)
                                   : (!w_lit && !r_prev_unlit && w_need_run);
        o_status.pre_zero  = (w_pre == 4'd0);
        o_status.post_zero = (w_post == 5'd0);
        o_status.cnt_last  = (r_cnt == 5'd1);
        o_status.slew_last = (r_rem <= SLEW_STEP);
        o_status.slot_free = !r_out_valid || i_out_ready;
    end

    // write configuration registers, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_blanks  <= PRE_RESET;
            r_post_blanks <= POST_RESET;
            r_min_dist    <= DIST_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRE_BLANKS:  r_pre_blanks  <= i_cfg_data[3:0];
                CFG_POST_BLANKS: r_post_blanks <= i_cfg_data[4:0];
                CFG_MIN_DIST:    r_min_dist    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // update the frame state on each accepted end-of-frame, lit or run-starting word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x           <= '0;
            r_prev_y           <= '0;
            r_prev_unlit       <= 1'b0;
            r_frame_has_output <= 1'b0;
        end else if (i_cmd.accept) begin
            if (w_eof) begin
                r_prev_x           <= '0;
                r_prev_y           <= '0;
                r_prev_unlit       <= 1'b0;
                r_frame_has_output <= 1'b0;
            end else if (w_lit || i_cmd.start_run) begin
                r_prev_x           <= i_pos_x;
                r_prev_y           <= i_pos_y;
                r_prev_unlit       <= !w_lit;
                r_frame_has_output <= 1'b1;
            end
        end
    end

    // run endpoints, remaining slew distance and copy counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_run) begin
            r_dep_x <= r_prev_x;
            r_dep_y <= r_prev_y;
            r_tgt_x <= w_tgt_x;
            r_tgt_y <= w_tgt_y;
            r_rem   <= w_dist;
            r_cnt   <= {1'b0, w_pre};
        end else if (i_cmd.emit_pre || i_cmd.emit_post) begin
            r_cnt <= r_cnt - 5'd1;
        end else if (i_cmd.emit_slew) begin
            if (r_rem <= SLEW_STEP) begin
                r_rem <= '0;
                r_cnt <= w_post;
            end else begin
                r_rem <= r_rem - SLEW_STEP;
            end
        end
    end

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // load the output word
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_last <= i_cmd.last;
            if (i_cmd.emit_lit) begin
                r_out_x     <= i_pos_x;
                r_out_y     <= i_pos_y;
                r_out_red   <= i_red;
                r_out_green <= i_green;
                r_out_blue  <= i_blue;
            end else begin
                r_out_x     <= i_cmd.emit_pre ? r_dep_x : r_tgt_x;
                r_out_y     <= i_cmd.emit_pre ? r_dep_y : r_tgt_y;
                r_out_red   <= '0;
                r_out_green <= '0;
                r_out_blue  <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_x       = r_out_x;
    assign o_out_y       = r_out_y;
    assign o_out_red     = r_out_red;
    assign o_out_green   = r_out_green;
    assign o_out_blue    = r_out_blue;
    assign o_last_of_run = r_out_last;

endmodule

// ===== src/laser_blank_inserter.sv =====
// An accepted lit word is loaded into the output register as it is accepted.
// Lit points and dropped words: one per cycle while the output register can take a word.
// Blanking run: pre + ceil(distance / 3276) + post copies (at most 53), one per cycle
// while the output register can take a word; input is held off meanwhile.
// Reset (synchronous, active low): position home, registers 3 / 16 / 50.
// ----------------------------------------------------------------------------
// laser_blank_inserter
// Inserts blanking runs between laser scanner points of a frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module laser_blank_inserter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input word
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [79:0] i_s_axis_tdata,   // pos_x, pos_y, red, green, blue
    input  logic        i_s_axis_tuser,   // command
    // output word
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // out_x, out_y, out_red, out_green, out_blue
    output logic        o_m_axis_tlast    // last_of_run
);
    import lbi_pkg::*;

    t_dp_cmd            w_cmd;
    t_dp_status         w_status;
    logic signed [15:0] w_out_x;
    logic signed [15:0] w_out_y;
    logic [15:0]        w_out_red;
    logic [15:0]        w_out_green;
    logic [15:0]        w_out_blue;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    lbi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (w_status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    lbi_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_command     (i_s_axis_tuser),
        .i_pos_x       (i_s_axis_tdata[15:0]),
        .i_pos_y       (i_s_axis_tdata[31:16]),
        .i_red         (i_s_axis_tdata[47:32]),
        .i_green       (i_s_axis_tdata[63:48]),
        .i_blue        (i_s_axis_tdata[79:64]),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_out_x       (w_out_x),
        .o_out_y       (w_out_y),
        .o_out_red     (w_out_red),
        .o_out_green   (w_out_green),
        .o_out_blue    (w_out_blue),
        .o_last_of_run (o_m_axis_tlast),
        .i_cmd         (w_cmd),
        .o_status      (w_status)
    );

    // pack the output word
    assign o_m_axis_tdata = {w_out_blue, w_out_green, w_out_red, w_out_y, w_out_x};

    // at most one word is loaded into the output register per cycle
    `ASSERT_ALWAYS(a_one_emit,
                   $onehot0({w_cmd.emit_lit, w_cmd.emit_pre, w_cmd.emit_slew, w_cmd.emit_post}),
                   "several emits in one cycle")
    // input is only taken when the output register can take a word
    `ASSERT_IMPLY(a_ready_slot, o_s_axis_tready, !o_m_axis_tvalid || i_m_axis_tready,
                  "input ready with output full")
    // no input is taken while a blanking run is in progress
    `ASSERT_IMPLY(a_run_stalls, w_cmd.emit_pre || w_cmd.emit_slew || w_cmd.emit_post,
                  !o_s_axis_tready, "input ready during run")
    // a started run never flags its end on the accepting cycle
    `ASSERT_IMPLY(a_start_no_last, w_cmd.start_run, !w_cmd.last && !w_cmd.emit_lit,
                  "run start marked last")

endmodule

// ===== test/laser_blank_inserter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// laser_blank_inserter_tb
// Self-checking bench for the blank inserter. Scan words go in on the slave
// stream; a scoreboard predicts the emitted beam words (lit pass-through,
// blanking runs, return-to-home at end of frame) and checks every output
// word in order. Covers boundary cases, register limits, output back-pressure
// and random frames under several register settings.
// ----------------------------------------------------------------------------
module laser_blank_inserter_tb;
    import lbi_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES  = 16;
    localparam int SINK_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_ERROR_LINES = 40;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_WORDS    = 38;

    // one input word: command plus point
    typedef struct packed {
        logic               cmd;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        red;
        logic [15:0]        green;
        logic [15:0]        blue;
    } t_scan_word;

    // one emitted beam word
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        red;
        logic [15:0]        green;
        logic [15:0]        blue;
        logic               last;
    } t_beam_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [79:0] i_s_axis_tdata = '0;   // pos_x, pos_y, red, green, blue
    logic        i_s_axis_tuser = 1'b0; // command
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [79:0] o_m_axis_tdata;        // out_x, out_y, out_red, out_green, out_blue
    logic        o_m_axis_tlast;        // last_of_run

    laser_blank_inserter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // scoreboard: beam words still owed by the block
    t_beam_word expected_beam[$];
    int error_count = 0;

    // shadow registers and beam state
    logic [3:0]         cfg_pre;
    logic [4:0]         cfg_post;
    logic [15:0]        cfg_min_dist;
    logic signed [15:0] beam_x;
    logic signed [15:0] beam_y;
    logic               beam_unlit;
    logic               frame_emitted;

    // idling controls
    bit src_gaps_on = 1'b1;
    bit sink_gaps_on = 1'b1;
    bit sink_hold_request = 1'b0;

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_ERROR_LINES)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic void reset_beam_state();
        beam_x = '0;
        beam_y = '0;
        beam_unlit = 1'b0;
        frame_emitted = 1'b0;
    endfunction

    function automatic void push_beam(input logic signed [15:0] x, input logic signed [15:0] y,
                                      input logic [15:0] r, input logic [15:0] g,
                                      input logic [15:0] b, input logic last);
        t_beam_word w;
        w.x = x;
        w.y = y;
        w.red = r;
        w.green = g;
        w.blue = b;
        w.last = last;
        expected_beam.insert(expected_beam.size(), w);
    endfunction

    // queue the blanking run from the beam position to the target; return its length
    function automatic int queue_blank_run(input logic signed [15:0] tx,
                                           input logic signed [15:0] ty);
        int dx;
        int dy;
        int span;
        int pre;
        int post;
        int copies;
        int total;
        dx = int'(beam_x) - int'(tx);
        dy = int'(beam_y) - int'(ty);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        span = (dx > dy) ? dx : dy;
        if (span <= int'(cfg_min_dist))
            return 0;
        pre = (cfg_pre > PRE_MAX) ? int'(PRE_MAX) : int'(cfg_pre);
        post = (cfg_post > POST_MAX) ? int'(POST_MAX) : int'(cfg_post);
        copies = (span + int'(SLEW_STEP) - 1) / int'(SLEW_STEP) + post;
        total = pre + copies;
        for (int i = 0; i < pre; i++)
            push_beam(beam_x, beam_y, '0, '0, '0, i == total - 1);
        for (int i = 0; i < copies; i++)
            push_beam(tx, ty, '0, '0, '0, pre + i == total - 1);
        return total;
    endfunction

    // predict the beam words caused by one accepted scan word
    function automatic void predict_scan_word(input t_scan_word w);
        if (w.cmd == CMD_EOF) begin
            if (frame_emitted)
                void'(queue_blank_run('0, '0));
            reset_beam_state();
        end else if (|{w.red, w.green, w.blue}) begin
            push_beam(w.x, w.y, w.red, w.green, w.blue, 1'b1);
            beam_x = w.x;
            beam_y = w.y;
            beam_unlit = 1'b0;
            frame_emitted = 1'b1;
        end else if (!beam_unlit) begin
            if (queue_blank_run(w.x, w.y) > 0) begin
                beam_x = w.x;
                beam_y = w.y;
                beam_unlit = 1'b1;
                frame_emitted = 1'b1;
            end
        end
    endfunction

    function automatic t_scan_word make_word(input logic cmd, input logic [15:0] x,
                                             input logic [15:0] y, input logic [15:0] r,
                                             input logic [15:0] g, input logic [15:0] b);
        t_scan_word w;
        w.cmd = cmd;
        w.x = x;
        w.y = y;
        w.red = r;
        w.green = g;
        w.blue = b;
        return w;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    // coordinate near the anchor, at an extreme, or anywhere
    function automatic logic [15:0] pick_coord(input logic signed [15:0] anchor);
        int roll;
        int v;
        roll = $urandom_range(0, 9);
        if (roll < 3) begin
            v = int'(anchor) + int'($urandom_range(0, 160)) - 80;
            return v[15:0];
        end
        if (roll == 3) begin
            case ($urandom_range(0, 3))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic t_scan_word random_point(input logic signed [15:0] ax,
                                                input logic signed [15:0] ay);
        t_scan_word w;
        int roll;
        w = make_word(CMD_POINT, pick_coord(ax), pick_coord(ay), '0, '0, '0);
        roll = $urandom_range(0, 19);
        if (roll >= 8 && roll < 11) begin
            // single bit in a single channel
            case ($urandom_range(0, 2))
                0: w.red = 16'd1 << $urandom_range(0, 15);
                1: w.green = 16'd1 << $urandom_range(0, 15);
                default: w.blue = 16'd1 << $urandom_range(0, 15);
            endcase
        end else if (roll >= 11) begin
            w.red = 16'($urandom_range(0, 65535));
            w.green = 16'($urandom_range(0, 65535));
            w.blue = 16'($urandom_range(0, 65535));
        end
        return w;
    endfunction

    // offer one scan word and hold it until accepted
    task automatic send_word(input t_scan_word w);
        int gap;
        gap = (src_gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= w.cmd;
        i_s_axis_tdata <= {w.blue, w.green, w.red, w.y, w.x};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_scan_word(w);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_PRE_BLANKS:  cfg_pre = data[3:0];
            CFG_POST_BLANKS: cfg_post = data[4:0];
            CFG_MIN_DIST:    cfg_min_dist = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stop offering, wait for every owed word, then let the block go quiet
    task automatic settle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_beam.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // receiver: random stalls, or one long hold when requested
    initial begin : sink_driver
        int stall;
        forever begin
            @(negedge i_clk);
            if (sink_hold_request) begin
                sink_hold_request = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (SINK_HOLD - 1) @(negedge i_clk);
            end else if (sink_gaps_on && $urandom_range(0, 3) == 0) begin
                stall = pick_gap();
                i_m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s: got %h, expected %h", name, got, want));
    endtask

    // compare each output word with the oldest expectation
    always @(posedge i_clk) begin : beam_checker
        t_beam_word want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_beam.size() == 0) begin
                report_error($sformatf("unexpected output word %h last %b",
                                       o_m_axis_tdata, o_m_axis_tlast));
            end else begin
                want = expected_beam.pop_front();
                check_field("out_x", o_m_axis_tdata[15:0], want.x);
                check_field("out_y", o_m_axis_tdata[31:16], want.y);
                check_field("out_red", o_m_axis_tdata[47:32], want.red);
                check_field("out_green", o_m_axis_tdata[63:48], want.green);
                check_field("out_blue", o_m_axis_tdata[79:64], want.blue);
                check_field("last_of_run", {15'd0, o_m_axis_tlast}, {15'd0, want.last});
            end
        end
    end

    // abort when no handshake completes for too long
    always @(posedge i_clk) begin : watchdog
        int stuck_cycles;
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // boundary cases under the reset register values
    task automatic test_point_cases();
        // unlit at home: no jump
        send_word(make_word(CMD_POINT, 16'h0000, 16'h0000, '0, '0, '0));
        send_word(make_word(CMD_POINT, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        // full-scale jump, then unlit after unlit
        send_word(make_word(CMD_POINT, 16'h8000, 16'h7FFF, '0, '0, '0));
        send_word(make_word(CMD_POINT, 16'h0000, 16'h0000, '0, '0, '0));
        send_word(make_word(CMD_POINT, 16'd100, 16'd100, 16'd1, '0, '0));
        // jump exactly at the threshold, then one past it
        send_word(make_word(CMD_POINT, 16'd150, 16'd60, '0, '0, '0));
        send_word(make_word(CMD_POINT, 16'd151, 16'd100, '0, '0, '0));
        send_word(make_word(CMD_POINT, 16'd151, 16'd100, '0, 16'd1, '0));
        send_word(make_word(CMD_POINT, 16'd0, 16'd0, '0, '0, 16'h8000));
        // end of frame already at home, fields ignored
        send_word(make_word(CMD_EOF, 16'd1234, 16'hBEEF, 16'd7, 16'd8, 16'd9));
        // empty frame
        send_word(make_word(CMD_EOF, '0, '0, '0, '0, '0));
        send_word(make_word(CMD_POINT, 16'd20000, -16'sd20000, 16'd5, 16'd6, 16'd7));
        send_word(make_word(CMD_EOF, '0, '0, '0, '0, '0));
        settle();
    endtask

    // register extremes, saturation and the unused index
    task automatic test_register_limits();
        write_register(CFG_PRE_BLANKS, 16'hABC0);
        write_register(CFG_POST_BLANKS, 16'hFFE0);
        write_register(CFG_MIN_DIST, 16'd0);
        send_word(make_word(CMD_POINT, 16'd1, 16'd1, 16'd3, '0, '0));
        send_word(make_word(CMD_POINT, 16'd2, 16'd1, '0, '0, '0));
        send_word(make_word(CMD_EOF, '0, '0, '0, '0, '0));
        settle();

        // out-of-range counts saturate; longest possible run
        write_register(CFG_PRE_BLANKS, 16'd15);
        write_register(CFG_POST_BLANKS, 16'd31);
        write_register(CFG_UNUSED, 16'hFFFF);
        send_word(make_word(CMD_POINT, 16'h7FFF, 16'h7FFF, 16'd9, 16'd9, 16'd9));
        send_word(make_word(CMD_POINT, 16'h8000, 16'h8000, '0, '0, '0));
        send_word(make_word(CMD_EOF, '0, '0, '0, '0, '0));
        settle();

        // largest threshold suppresses every run
        write_register(CFG_PRE_BLANKS, {12'd0, PRE_MAX});
        write_register(CFG_POST_BLANKS, {11'd0, POST_MAX});
        write_register(CFG_MIN_DIST, 16'hFFFF);
        send_word(make_word(CMD_POINT, 16'h8000, 16'd0, '0, 16'd4, '0));
        send_word(make_word(CMD_POINT, 16'h7FFF, 16'd0, '0, '0, '0));
        send_word(make_word(CMD_EOF, '0, '0, '0, '0, '0));
        settle();
    endtask

    // receiver holds off while long runs pile up behind it
    task automatic test_output_backpressure();
        logic signed [15:0] far;
        write_register(CFG_PRE_BLANKS, {12'd0, PRE_RESET});
        write_register(CFG_POST_BLANKS, {11'd0, POST_RESET});
        write_register(CFG_MIN_DIST, DIST_RESET);
        src_gaps_on = 1'b0;
        sink_hold_request = 1'b1;
        for (int i = 0; i < 5; i++) begin
            far = (i % 2 == 0) ? 16'sd30000 : -16'sd30000;
            send_word(make_word(CMD_POINT, far, 16'($urandom_range(0, 65535)),
                                16'd100, 16'd200, 16'd300));
            send_word(make_word(CMD_POINT, -far, 16'($urandom_range(0, 65535)),
                                '0, '0, '0));
        end
        send_word(make_word(CMD_EOF, '0, '0, '0, '0, '0));
        settle();
        src_gaps_on = 1'b1;
    endtask

    task automatic configure_phase(input int phase);
        logic [15:0] junk;
        junk = 16'($urandom_range(0, 65535));
        case (phase)
            0: begin
                write_register(CFG_PRE_BLANKS, {12'd0, PRE_RESET});
                write_register(CFG_POST_BLANKS, {11'd0, POST_RESET});
                write_register(CFG_MIN_DIST, DIST_RESET);
            end
            1: begin
                write_register(CFG_PRE_BLANKS, 16'd0);
                write_register(CFG_POST_BLANKS, 16'd0);
                write_register(CFG_MIN_DIST, 16'd0);
            end
            2: begin
                write_register(CFG_PRE_BLANKS, {junk[15:4], 4'd15});
                write_register(CFG_POST_BLANKS, {junk[15:5], 5'd31});
                write_register(CFG_MIN_DIST, 16'd0);
            end
            3: begin
                write_register(CFG_MIN_DIST, 16'hFFFF);
                write_register(CFG_PRE_BLANKS, 16'd8);
                write_register(CFG_POST_BLANKS, 16'd24);
            end
            default: begin
                write_register(CFG_POST_BLANKS, 16'($urandom_range(0, 65535)));
                write_register(CFG_PRE_BLANKS, 16'($urandom_range(0, 65535)));
                if ($urandom_range(0, 3) == 0)
                    write_register(CFG_MIN_DIST, 16'($urandom_range(0, 65535)));
                else
                    write_register(CFG_MIN_DIST, 16'($urandom_range(0, 300)));
                write_register(CFG_UNUSED, junk);
            end
        endcase
    endtask

    // random frames with random content, some noise words mixed in
    task automatic test_random_frames();
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        t_scan_word w;
        logic [95:0] noise;
        int sent;
        int frame_len;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            configure_phase(phase);
            ax = '0;
            ay = '0;
            sent = 0;
            while (sent < PHASE_WORDS) begin
                src_gaps_on = (phase != 2) && ($urandom_range(0, 3) != 0);
                sink_gaps_on = (phase != 2) && ($urandom_range(0, 3) != 0);
                frame_len = $urandom_range(1, 12);
                for (int i = 0; i < frame_len; i++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        noise = {$urandom(), $urandom(), $urandom()};
                        w = noise[80:0];
                    end else begin
                        w = random_point(ax, ay);
                    end
                    if (w.cmd == CMD_EOF) begin
                        ax = '0;
                        ay = '0;
                    end else begin
                        ax = w.x;
                        ay = w.y;
                    end
                    send_word(w);
                    sent++;
                end
                w = random_point(ax, ay);
                w.cmd = CMD_EOF;
                send_word(w);
                sent++;
                ax = '0;
                ay = '0;
            end
            settle();
        end
        src_gaps_on = 1'b1;
        sink_gaps_on = 1'b1;
    endtask

    initial begin
        cfg_pre = PRE_RESET;
        cfg_post = POST_RESET;
        cfg_min_dist = DIST_RESET;
        reset_beam_state();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_point_cases();
        test_register_limits();
        test_output_backpressure();
        test_random_frames();
        settle();

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
